[rtl/core/thpd_pkg.sv]
// Shared constants and types for the table Huffman packet decoder.
package thpd_pkg;

  localparam int MAX_OUT_DEF   = 2048;
  localparam int PEEK_BITS_DEF = 11;

  localparam int IN_IDX_W    = 11;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int ENTRY_W     = SYM_W + LEN_W;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 8;
  localparam int M_TUSER_W   = 2;
  localparam int MAX_RESULTS = 18;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [BYTE_W-1:0] RAW_HEADER = 8'h80;
  localparam logic [BYTE_W-1:0] MAX_PAD    = 8'd8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  typedef struct packed {
    logic              error;
    logic              last;
    logic              valid;
    logic [BYTE_W-1:0] data;
  } result_t;

endpackage

[rtl/core/thpd_table_ram.sv]
// Decode table memory: one write port, one registered read port.
module thpd_table_ram #(
  parameter int ADDR_W = thpd_pkg::PEEK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [thpd_pkg::ENTRY_W-1:0]  wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [thpd_pkg::ENTRY_W-1:0]  rdata
);

  logic [thpd_pkg::ENTRY_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read so a stalled lookup keeps its entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/thpd_out_reg.sv]
// Output register that parts the decoder from the result stream.
module thpd_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  thpd_pkg::result_t               res,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [thpd_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] out_byte
  output logic [thpd_pkg::M_TUSER_W-1:0]  m_tuser,  // [0] out_valid, [1] out_error
  output logic                            m_tlast   // out_last
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= res.data;
      m_tuser <= {res.error, res.valid};
      m_tlast <= res.last;
    end
  end

endmodule

[rtl/core/thpd_decoder.sv]
// Packet control, bit buffer and table lookup sequencer.
module thpd_decoder #(
  parameter int MAX_OUT   = thpd_pkg::MAX_OUT_DEF,
  parameter int PEEK_BITS = thpd_pkg::PEEK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [thpd_pkg::IN_IDX_W-1:0]  in_index,
  input  logic [thpd_pkg::SYM_W-1:0]     in_symbol,
  input  logic [thpd_pkg::LEN_W-1:0]     in_length,
  input  logic [thpd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                           in_last,
  output logic                           ram_we,
  output logic [PEEK_BITS-1:0]           ram_waddr,
  output logic [thpd_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic                           ram_re,
  output logic [PEEK_BITS-1:0]           ram_raddr,
  input  logic [thpd_pkg::ENTRY_W-1:0]   ram_rdata,
  output logic                           push,
  output thpd_pkg::result_t              push_res,
  input  logic                           out_free
);

  localparam int BUF_W  = PEEK_BITS + thpd_pkg::BYTE_W;
  localparam int CNT_W  = $clog2(BUF_W + 1);
  localparam int OCNT_W = $clog2(MAX_OUT + 1);
  localparam int PAD_W  = 4;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_LOOKUP, S_FINISH} state_t;

  state_t                      state;
  logic [BUF_W-1:0]            bit_buffer;
  logic [CNT_W-1:0]            bit_count;
  logic                        in_packet;
  logic                        raw_mode;
  logic [PAD_W-1:0]            pad_bits;
  logic [OCNT_W-1:0]           out_count;
  logic                        halted;
  logic                        failed;
  logic                        final_step;
  logic [thpd_pkg::NRES_W-1:0] nres;
  logic                        pend_valid;
  logic [thpd_pkg::BYTE_W-1:0] pend_byte;

  logic                        go;
  logic                        cap_hit;
  logic [thpd_pkg::LEN_W-1:0]  rd_len;
  logic [CNT_W-1:0]            len_c;
  logic                        hdr_raw;
  logic                        hdr_bad;
  logic [PEEK_BITS-1:0]        peek_idx;

  assign in_ready  = (state == S_IDLE);
  assign ram_we    = in_valid && in_ready && (in_mode == thpd_pkg::MODE_LOAD);
  assign ram_waddr = PEEK_BITS'(in_index);
  assign ram_wdata = {in_length, in_symbol};

  assign hdr_raw = (in_byte == thpd_pkg::RAW_HEADER);
  assign hdr_bad = !hdr_raw && (in_byte > thpd_pkg::MAX_PAD);

  // The first stream bit is the most significant index bit.
  always_comb begin
    for (int k = 0; k < PEEK_BITS; k++) begin
      peek_idx[PEEK_BITS-1-k] = bit_buffer[k];
    end
  end

  assign go = !halted && (nres < thpd_pkg::NRES_W'(thpd_pkg::MAX_RESULTS))
              && (bit_count > CNT_W'(pad_bits))
              && (final_step || (bit_count >= CNT_W'(PEEK_BITS)));
  assign cap_hit   = (out_count >= OCNT_W'(MAX_OUT));
  assign ram_re    = (state == S_CHECK) && go && !cap_hit;
  assign ram_raddr = peek_idx;

  assign rd_len = ram_rdata[thpd_pkg::ENTRY_W-1 -: thpd_pkg::LEN_W];
  assign len_c  = (CNT_W'(rd_len) > CNT_W'(PEEK_BITS)) ? CNT_W'(PEEK_BITS) : CNT_W'(rd_len);

  always_comb begin
    push     = 1'b0;
    push_res = '{error: 1'b0, last: 1'b0, valid: 1'b1, data: pend_byte};
    unique case (state)
      S_LOOKUP: begin
        push = (rd_len != '0) && pend_valid && out_free;
      end
      S_FINISH: begin
        if (pend_valid) begin
          push     = out_free;
          push_res = '{error: final_step && failed, last: final_step, valid: 1'b1,
                       data: pend_byte};
        end else begin
          // A final byte with no data result closes the packet with an empty marker.
          push     = final_step && out_free;
          push_res = '{error: failed, last: 1'b1, valid: 1'b0, data: '0};
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_buffer <= '0;
      bit_count  <= '0;
      in_packet  <= 1'b0;
      raw_mode   <= 1'b0;
      pad_bits   <= '0;
      out_count  <= '0;
      halted     <= 1'b0;
      failed     <= 1'b0;
      final_step <= 1'b0;
      nres       <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && (in_mode == thpd_pkg::MODE_BYTE)) begin
            final_step <= in_last;
            nres       <= '0;
            if (!in_packet) begin
              in_packet <= 1'b1;
              raw_mode  <= hdr_raw;
              pad_bits  <= PAD_W'(in_byte);
              if (hdr_bad) begin
                halted <= 1'b1;
                failed <= 1'b1;
              end
              state <= S_FINISH;
            end else if (raw_mode) begin
              pend_valid <= 1'b1;
              pend_byte  <= in_byte;
              nres       <= thpd_pkg::NRES_W'(1);
              state      <= S_FINISH;
            end else begin
              if (!halted) begin
                bit_buffer <= bit_buffer | (BUF_W'(in_byte) << bit_count);
                bit_count  <= bit_count + CNT_W'(thpd_pkg::BYTE_W);
              end
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!go) begin
            state <= S_FINISH;
          end else if (cap_hit) begin
            halted <= 1'b1;
            failed <= 1'b1;
            state  <= S_FINISH;
          end else begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (rd_len == '0) begin
            halted <= 1'b1;
            failed <= 1'b1;
            state  <= S_FINISH;
          end else if (!pend_valid || out_free) begin
            pend_valid <= 1'b1;
            pend_byte  <= ram_rdata[thpd_pkg::SYM_W-1:0];
            nres       <= nres + 1'b1;
            out_count  <= out_count + 1'b1;
            if (len_c >= bit_count) begin
              bit_buffer <= '0;
              bit_count  <= '0;
            end else begin
              bit_buffer <= bit_buffer >> len_c;
              bit_count  <= bit_count - len_c;
            end
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if ((pend_valid || final_step) ? out_free : 1'b1) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
            if (final_step) begin
              bit_buffer <= '0;
              bit_count  <= '0;
              in_packet  <= 1'b0;
              raw_mode   <= 1'b0;
              pad_bits   <= '0;
              out_count  <= '0;
              halted     <= 1'b0;
              failed     <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_fits: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(BUF_W))
    else $error("bit count exceeds buffer width");

  a_cap_held: assert property (@(posedge clk) disable iff (rst)
    out_count <= OCNT_W'(MAX_OUT))
    else $error("symbol count passed the output cap");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");

  a_lookup_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) && !$past(state == S_LOOKUP) |-> $past(ram_re))
    else $error("lookup entered without a table read");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left over between requests");

endmodule

[rtl/core/table_huffman_packet_decoder_unit.sv]
// Top level of the table-driven Huffman packet decoder.
//
//  channel   direction  fields
//  s_*       in         tuser: mode; tdata: table_index, table_symbol,
//                       table_length, in_byte; tlast: in_last
//  m_*       out        tdata: out_byte; tuser: out_valid, out_error;
//                       tlast: out_last
//
// A table load is written as the request is accepted. A header or raw byte goes
// through the finish state. A coded byte goes through the check state and, per
// symbol, a table read from the single read port of the table memory and a step
// that uses the entry and shifts the buffer; a zero-length entry halts the packet.
// Results leave through one output register; the decoder stalls on a full
// register. Reset clears the packet state; the table is undefined until loaded.
module table_huffman_packet_decoder_unit #(
  parameter int MAX_OUT   = thpd_pkg::MAX_OUT_DEF,
  parameter int PEEK_BITS = thpd_pkg::PEEK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [10:0] table_index, [18:11] table_symbol, [22:19] table_length,
  // [30:23] in_byte, [31] zero
  input  logic [thpd_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,  // mode
  input  logic                            s_tlast,  // in_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [thpd_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] out_byte
  output logic [thpd_pkg::M_TUSER_W-1:0]  m_tuser,  // [0] out_valid, [1] out_error
  output logic                            m_tlast   // out_last
);

  logic                          ram_we;
  logic [PEEK_BITS-1:0]          ram_waddr;
  logic [thpd_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [PEEK_BITS-1:0]          ram_raddr;
  logic [thpd_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          push;
  thpd_pkg::result_t             push_res;
  logic                          out_free;

  thpd_decoder #(
    .MAX_OUT   (MAX_OUT),
    .PEEK_BITS (PEEK_BITS)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_index  (s_tdata[10:0]),
    .in_symbol (s_tdata[18:11]),
    .in_length (s_tdata[22:19]),
    .in_byte   (s_tdata[30:23]),
    .in_last   (s_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .push_res  (push_res),
    .out_free  (out_free)
  );

  thpd_table_ram #(
    .ADDR_W (PEEK_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  thpd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (push_res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[test/tb.sv]
// Self-checking testbench for the table Huffman packet decoder, with random stream pacing.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OUT      = thpd_pkg::MAX_OUT_DEF;
  localparam int PEEK         = thpd_pkg::PEEK_BITS_DEF;
  localparam int TBL_SIZE     = 1 << PEEK;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 410;

  localparam int S_TDATA_W = thpd_pkg::S_TDATA_W;
  localparam int M_TDATA_W = thpd_pkg::M_TDATA_W;
  localparam int M_TUSER_W = thpd_pkg::M_TUSER_W;
  localparam int ENTRY_W   = thpd_pkg::ENTRY_W;
  localparam int IN_IDX_W  = thpd_pkg::IN_IDX_W;
  localparam int SYM_W     = thpd_pkg::SYM_W;
  localparam int LEN_W     = thpd_pkg::LEN_W;
  localparam int BYTE_W    = thpd_pkg::BYTE_W;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  // Shadow of the decoder: table, bit buffer and packet state.
  logic [ENTRY_W-1:0] decode_tbl [TBL_SIZE];
  logic [31:0]        bit_buf;
  int                 bit_cnt;
  int                 pad_bits;
  int                 sym_count;
  bit                 in_pkt;
  bit                 raw_pkt;
  bit                 halted;
  bit                 failed;

  thpd_pkg::result_t pending_results [$];
  int      fail_count;
  int      cycle_count;
  int      burst_left;
  bit      calm;
  int      rx_style;
  int      rx_hold;
  int      rx_cycles;

  table_huffman_packet_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_packet();
    bit_buf   = '0;
    bit_cnt   = 0;
    pad_bits  = 0;
    sym_count = 0;
    in_pkt    = 1'b0;
    raw_pkt   = 1'b0;
    halted    = 1'b0;
    failed    = 1'b0;
  endfunction

  // Works out the results that one accepted request causes.
  function automatic void decode_item(input logic mode, input logic [S_TDATA_W-1:0] data,
                                      input logic last);
    logic [IN_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]   b;
    logic [ENTRY_W-1:0]  ent;
    int                  len;
    int                  n;
    int                  k;
    thpd_pkg::result_t   r;
    idx = data[10:0];
    b   = data[30:23];
    n   = 0;
    if (mode == thpd_pkg::MODE_LOAD) begin
      decode_tbl[idx] = data[22:11];
      return;
    end
    if (!in_pkt) begin
      in_pkt   = 1'b1;
      raw_pkt  = (b == thpd_pkg::RAW_HEADER);
      pad_bits = int'(b);
      if (!raw_pkt && b > thpd_pkg::MAX_PAD) begin
        halted = 1'b1;
        failed = 1'b1;
      end
    end else if (raw_pkt) begin
      pending_results.push_back('{error: 1'b0, last: 1'b0, valid: 1'b1, data: b});
      n++;
    end else begin
      if (!halted) begin
        bit_buf = bit_buf | (32'(b) << bit_cnt);
        bit_cnt += 8;
      end
      while (!halted && n < thpd_pkg::MAX_RESULTS) begin
        // Mid-packet a symbol needs a full peek window; the final byte flushes.
        if (bit_cnt <= pad_bits) break;
        if (!last && bit_cnt < PEEK) break;
        if (sym_count >= MAX_OUT) begin
          halted = 1'b1;
          failed = 1'b1;
          break;
        end
        idx = '0;
        for (k = 0; k < PEEK; k++) idx = {idx[IN_IDX_W-2:0], bit_buf[k]};
        ent = decode_tbl[idx];
        len = int'(ent[ENTRY_W-1:SYM_W]);
        if (len == 0) begin
          halted = 1'b1;
          failed = 1'b1;
          break;
        end
        if (len > PEEK) len = PEEK;
        pending_results.push_back('{error: 1'b0, last: 1'b0, valid: 1'b1,
                                    data: ent[SYM_W-1:0]});
        n++;
        sym_count++;
        if (len >= bit_cnt) begin
          bit_buf = '0;
          bit_cnt = 0;
        end else begin
          bit_buf = bit_buf >> len;
          bit_cnt -= len;
        end
      end
    end
    if (last) begin
      if (n == 0) pending_results.push_back('{error: 1'b0, last: 1'b0, valid: 1'b0, data: '0});
      r = pending_results.pop_back();
      r.last  = 1'b1;
      r.error = failed;
      pending_results.push_back(r);
      clear_packet();
    end
  endfunction

  // Predicts on input handshakes and checks output handshakes.
  always @(posedge clk) begin
    thpd_pkg::result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) decode_item(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_byte %0h out_valid %0b out_last %0b out_error %0b",
                 m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, m_tdata);
            fail_count++;
          end
          if (m_tuser[0] !== want.valid) begin
            $error("out_valid: expected %0b, got %0b", want.valid, m_tuser[0]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, m_tlast);
            fail_count++;
          end
          if (m_tuser[1] !== want.error) begin
            $error("out_error: expected %0b, got %0b", want.error, m_tuser[1]);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver switches among four randomly chosen stall styles over the run.
  always @(posedge clk) begin
    bit ready_next;
    rx_cycles++;
    if (rx_cycles % 300 == 0) rx_style = $urandom_range(0, 3);
    if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      ready_next = 1'b1;
      case (rx_style)
        0: begin
          ready_next = 1'b1;
          rx_hold    = $urandom_range(5, 40);
        end
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = ($urandom_range(0, 5) != 0);
        default: begin
          ready_next = !m_tready;
          rx_hold    = $urandom_range(0, 10);
        end
      endcase
      m_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] random_length(input bit allow_zero);
    if (allow_zero && $urandom_range(0, 39) == 0) return '0;
    if ($urandom_range(0, 15) == 0) return LEN_W'($urandom_range(PEEK + 1, 15));
    return LEN_W'($urandom_range(1, PEEK));
  endfunction

  // Sends one request; the sender idles between bursts unless calm is set.
  task automatic send_req(input logic mode, input logic [IN_IDX_W-1:0] idx,
                          input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                          input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = calm ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {1'b0, b, len, sym, idx};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    send_req(thpd_pkg::MODE_BYTE, IN_IDX_W'($urandom_range(0, TBL_SIZE - 1)),
             SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 15)), b, last);
  endtask

  task automatic send_load(input logic [IN_IDX_W-1:0] idx, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len);
    send_req(thpd_pkg::MODE_LOAD, idx, sym, len, BYTE_W'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Every entry is written before any lookup can happen.
  task automatic test_table_fill();
    int i;
    calm = 1'b1;
    for (i = 0; i < TBL_SIZE; i++) begin
      send_load(IN_IDX_W'(i), SYM_W'($urandom_range(0, 255)), random_length(1'b0));
    end
    calm = 1'b0;
  endtask

  task automatic test_header_only();
    send_byte(8'h00, 1'b1);
    send_byte(thpd_pkg::RAW_HEADER, 1'b1);
    send_byte(thpd_pkg::MAX_PAD, 1'b1);
  endtask

  task automatic test_raw_packets();
    send_byte(thpd_pkg::RAW_HEADER, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_bad_header();
    send_byte(8'h09, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_pad_beyond_payload();
    send_byte(thpd_pkg::MAX_PAD, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_zero_length();
    send_load('0, 8'h00, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_load('0, 8'h00, 4'd3);
  endtask

  // A stored length above the peek width is clamped to the peek width.
  task automatic test_long_code();
    send_load('1, 8'hff, 4'd15);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_load_in_packet();
    send_byte(8'h02, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_load(11'd5, 8'h77, 4'd4);
    send_byte(8'hc3, 1'b1);
  endtask

  // All-zero payload with a one-bit code at index zero runs into the output cap.
  task automatic test_output_cap();
    int i;
    send_load('0, 8'h5e, 4'd1);
    send_byte(8'h00, 1'b0);
    for (i = 1; i <= MAX_OUT / 8 + 3; i++) send_byte(8'h00, i == MAX_OUT / 8 + 3);
    wait_drained();
    send_load('0, 8'h21, random_length(1'b0));
  endtask

  task automatic test_random_packets();
    int  sent;
    int  plen;
    int  sel;
    int  i;
    logic [BYTE_W-1:0] hdr;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      sel = $urandom_range(0, 19);
      if (sel < 14) hdr = BYTE_W'($urandom_range(0, int'(thpd_pkg::MAX_PAD)));
      else if (sel < 16) hdr = thpd_pkg::RAW_HEADER;
      else if (sel < 18) begin
        hdr = BYTE_W'($urandom_range(int'(thpd_pkg::MAX_PAD) + 1, 255));
        if (hdr == thpd_pkg::RAW_HEADER) hdr = 8'hff;
      end else hdr = BYTE_W'($urandom_range(0, 255));
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) begin
        send_load(IN_IDX_W'($urandom_range(0, TBL_SIZE - 1)), SYM_W'($urandom_range(0, 255)),
                  random_length(1'b1));
        sent++;
      end
      send_byte(hdr, plen == 0);
      sent++;
      for (i = 1; i <= plen; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_load(IN_IDX_W'($urandom_range(0, TBL_SIZE - 1)),
                    SYM_W'($urandom_range(0, 255)), random_length(1'b1));
          sent++;
        end
        send_byte(BYTE_W'($urandom_range(0, 255)), i == plen);
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= thpd_pkg::MODE_BYTE;
    s_tlast    <= 1'b0;
    m_tready   <= 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    calm        = 1'b0;
    rx_style    = 0;
    rx_hold     = 0;
    rx_cycles   = 0;
    clear_packet();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_fill();
    test_header_only();
    test_raw_packets();
    test_bad_header();
    test_pad_beyond_payload();
    wait_drained();
    test_zero_length();
    test_long_code();
    test_load_in_packet();
    wait_drained();
    test_output_cap();
    test_random_packets();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/core/thpd_pkg.sv
rtl/core/thpd_table_ram.sv
rtl/core/thpd_out_reg.sv
rtl/core/thpd_decoder.sv
rtl/core/table_huffman_packet_decoder_unit.sv
test/tb.sv
